// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/imm_pkg.sv =====
// Shared constants and types for the integer matrix multiply unit.
package imm_pkg;

  localparam int MAX_DIM     = 4;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int NDIM_W      = $clog2(MAX_DIM + 1);
  localparam int DIM_W       = 3;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int SUM_W       = 34;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(3);

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } imm_state_t;

  typedef struct packed {
    logic load;
    logic start;
  } imm_cmd_t;

  typedef struct packed {
    logic load_last;
    logic done;
  } imm_stat_t;

endpackage

// ===== hdl/imm_ctrl.sv =====
// Controller: alternates between loading the operand stores and running the product.
module imm_ctrl
  import imm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  imm_stat_t  stat,
  output imm_cmd_t   cmd,
  output imm_state_t state
);

  imm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && stat.load_last) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.done) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.start = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        cmd.start = in_valid && stat.load_last;
      end
      ST_RUN: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// ===== hdl/imm_datapath.sv =====
// Datapath: operand stores, index sequencer, multiply-accumulate pipeline, result register.
module imm_datapath
  import imm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [DIM_W-1:0]        cfg_wr_data,
  input  imm_cmd_t                cmd,
  output imm_stat_t               stat,
  input  logic signed [VAL_W-1:0] a_value,
  input  logic signed [VAL_W-1:0] b_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] product_value,
  output logic                    last_of_matrix
);

  logic [DIM_W-1:0]   dim;
  logic [NDIM_W-1:0]  n_act;
  logic [IDX_W-1:0]   n_m1;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] load_count;

  logic signed [VAL_W-1:0] a_store [STORE_DEPTH];
  logic signed [VAL_W-1:0] b_store [STORE_DEPTH];

  logic             issuing;
  logic [IDX_W-1:0] i_idx, j_idx, k_idx;
  logic [ADDR_W-1:0] a_addr, b_addr;
  logic             last_k, last_j, last_i;
  logic             advance;

  logic                    s1_valid, s1_first, s1_lastk, s1_lastel;
  logic signed [VAL_W-1:0] a_rd, b_rd;
  logic                    s2_valid, s2_first, s2_lastk, s2_lastel;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] acc_base;
  logic signed [SUM_W-1:0] sum;

  // A zero dimension acts as one, and anything above the maximum is clamped.
  always_comb begin
    if (dim == '0) begin
      n_act = NDIM_W'(1);
    end else if (int'(dim) > MAX_DIM) begin
      n_act = NDIM_W'(MAX_DIM);
    end else begin
      n_act = NDIM_W'(dim);
    end
  end

  assign n_m1  = IDX_W'(n_act - NDIM_W'(1));
  assign total = COUNT_W'(n_act) * COUNT_W'(n_act);

  assign stat.load_last = (load_count == total - COUNT_W'(1));
  assign stat.done      = out_valid && out_ready && last_of_matrix;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim        <= DIM_RESET;
      load_count <= '0;
    end else if (cfg_wr_en) begin
      dim        <= cfg_wr_data;
      load_count <= '0;
    end else if (cmd.start) begin
      load_count <= '0;
    end else if (cmd.load) begin
      load_count <= load_count + COUNT_W'(1);
    end
  end

  // The whole pipeline holds while a finished result waits to be taken.
  assign advance = !out_valid || out_ready;

  assign a_addr = ADDR_W'(ADDR_W'(i_idx) * ADDR_W'(n_act) + ADDR_W'(k_idx));
  assign b_addr = ADDR_W'(ADDR_W'(k_idx) * ADDR_W'(n_act) + ADDR_W'(j_idx));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_store[load_count[ADDR_W-1:0]] <= a_value;
      b_store[load_count[ADDR_W-1:0]] <= b_value;
    end
    if (advance) begin
      a_rd <= a_store[a_addr];
      b_rd <= b_store[b_addr];
    end
  end

  assign last_k = (k_idx == n_m1);
  assign last_j = (j_idx == n_m1);
  assign last_i = (i_idx == n_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      i_idx   <= '0;
      j_idx   <= '0;
      k_idx   <= '0;
    end else if (cmd.start) begin
      issuing <= 1'b1;
      i_idx   <= '0;
      j_idx   <= '0;
      k_idx   <= '0;
    end else if (issuing && advance) begin
      if (last_k) begin
        k_idx <= '0;
        if (last_j) begin
          j_idx <= '0;
          if (last_i) begin
            issuing <= 1'b0;
          end else begin
            i_idx <= i_idx + IDX_W'(1);
          end
        end else begin
          j_idx <= j_idx + IDX_W'(1);
        end
      end else begin
        k_idx <= k_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= issuing;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_first  <= (k_idx == '0);
      s1_lastk  <= last_k;
      s1_lastel <= last_k && last_j && last_i;
      s2_first  <= s1_first;
      s2_lastk  <= s1_lastk;
      s2_lastel <= s1_lastel;
      s2_prod   <= a_rd * b_rd;
    end
  end

  // Each element's sum restarts from zero on its first term.
  assign acc_base = s2_first ? '0 : acc;
  assign sum      = acc_base + SUM_W'(s2_prod);

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      acc <= sum;
      if (s2_lastk) begin
        product_value  <= sum;
        last_of_matrix <= s2_lastel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid && s2_lastk;
    end
  end

endmodule

// ===== hdl/integer_matrix_multiply_unit.sv =====
// Integer matrix multiply unit: loads A and B, then streams C = A x B in row-major order.
// A load takes one request per cycle, N*N requests in all, where N is dim_in_use
// (zero acts as one, values above the maximum dimension are clamped). The request
// that completes the load starts the product, and no further request is taken until
// the last element of C has been delivered. One multiply-accumulate unit computes the
// product, one term per cycle while the output is not stalled, through a pipeline of
// store read, multiply and accumulate; a stalled output holds the whole pipeline.
// Writing dim_in_use discards a partial load.
`include "assert_macros.svh"

module integer_matrix_multiply_unit
  import imm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [DIM_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] a_value,
  input  logic signed [VAL_W-1:0] b_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] product_value,
  output logic                    last_of_matrix
);

  imm_cmd_t   cmd;
  imm_stat_t  stat;
  imm_state_t state;

  imm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  imm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .stat           (stat),
    .a_value        (a_value),
    .b_value        (b_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .product_value  (product_value),
    .last_of_matrix (last_of_matrix)
  );

  // Loading and result delivery never overlap.
  `CHK_IMPLY(a_no_overlap, clk, rst, out_valid, !in_ready)
  // The request that completes a load puts the unit into its run phase.
  `CHK_NEXT(a_start_runs, clk, rst, cmd.start, (state == ST_RUN) && !in_ready)
  // Delivering the final element of C reopens the input.
  `CHK_NEXT(a_done_reload, clk, rst, out_valid && out_ready && last_of_matrix,
            in_ready && !out_valid)

endmodule
